// ----- rtl/periodic_task_dispatcher_core_assert.svh -----
// Assertion macros for the periodic task dispatcher.
// Depends on nothing; included by the top level only.
`ifndef PERIODIC_TASK_DISPATCHER_CORE_ASSERT_SVH
`define PERIODIC_TASK_DISPATCHER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PTD_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error("ptd assertion failed");
`define PTD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error("ptd assertion failed");
`else
`define PTD_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons)
`define PTD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

// ----- rtl/ptd_pkg.sv -----
// Shared types and constants of the periodic task dispatcher.
// Depends on nothing; used by the interfaces and the core.
package ptd_pkg;

	localparam int TASK_SLOTS = 8;
	localparam int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int MAX_OUT    = 8;
	localparam int CNT_W      = 32;
	localparam int PER_W      = 16;
	localparam int BIT_W      = $clog2(CNT_W);
	localparam int OP_W       = 3;
	localparam int SLOT_W     = 3;
	localparam int TASK_W     = 3;
	localparam int EMIT_W     = $clog2(MAX_OUT);

	typedef enum logic [OP_W-1:0] {
		OP_TICK     = 3'd0,
		OP_CREATE   = 3'd1,
		OP_DELETE   = 3'd2,
		OP_SUSPEND  = 3'd3,
		OP_ACTIVATE = 3'd4
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CRD,
		ST_TRD,
		ST_TCHK,
		ST_TDIV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic             used;
		logic             active;
		logic [PER_W-1:0] period;
	} slot_entry_t;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_DUE    = 1'b1;
	localparam logic STAT_OK     = 1'b0;
	localparam logic STAT_REJ    = 1'b1;

endpackage

// ----- rtl/ptd_if.sv -----
// Valid/ready channel interfaces for the periodic task dispatcher.
// Depends on ptd_pkg for field widths.
interface ptd_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [ptd_pkg::OP_W-1:0]      opcode;
	logic [ptd_pkg::SLOT_W-1:0]    slot;
	logic [ptd_pkg::PER_W-1:0]     period;
	modport source (output valid, output opcode, output slot, output period, input ready);
	modport sink (input valid, input opcode, input slot, input period, output ready);
endinterface

interface ptd_res_if;
	logic                          valid;
	logic                          ready;
	logic                          kind;
	logic                          status;
	logic [ptd_pkg::TASK_W-1:0]    due_task;
	logic                          last;
	modport source (output valid, output kind, output status, output due_task, output last,
		input ready);
	modport sink (input valid, input kind, input status, input due_task, input last,
		output ready);
endinterface

// ----- rtl/periodic_task_dispatcher_core.sv -----
// Periodic task dispatcher: a command beat (tick, create, delete, suspend, activate) goes in
// on cmd, status and due-task beats come out on res. One beat is taken at a time. For a
// command the slot is read in the accepting cycle, then modified, written back and answered
// with the status beat in ST_CRD once res is free. A tick reads each slot in turn (ST_TRD,
// ST_TCHK) and, for an active slot with nonzero period, runs the one-bit-per-cycle remainder
// unit that divides the 32-bit tick count by the slot period (ST_TDIV); then ST_EMIT sends
// one due beat per cycle while res is not stalled, and no beat when none is due.
// Reset clears the table through per-slot valid bits; there is no clearing pass.
// Depends on ptd_pkg, ptd_if.sv and periodic_task_dispatcher_core_assert.svh.
`include "periodic_task_dispatcher_core_assert.svh"

module periodic_task_dispatcher_core (
	input  logic      clk,
	input  logic      arst_n,
	ptd_cmd_if.sink   cmd,
	ptd_res_if.source res
);

	localparam int IW = ptd_pkg::IDX_W;
	localparam int PW = ptd_pkg::PER_W;
	localparam int CW = ptd_pkg::CNT_W;
	localparam int EW = ptd_pkg::EMIT_W;
	localparam int NS = ptd_pkg::TASK_SLOTS;

	ptd_pkg::state_t state_q, state_d;

	ptd_pkg::slot_entry_t mem_q [NS];
	ptd_pkg::slot_entry_t rd_data_q;
	logic                 rd_vld_q;
	logic [NS-1:0]        vld_q;
	logic [IW-1:0]        rd_addr;

	logic [ptd_pkg::OP_W-1:0]   op_q;
	logic [ptd_pkg::SLOT_W-1:0] slot_q;
	logic [PW-1:0]              per_in_q;

	logic [CW-1:0]                  tick_q;
	logic [IW-1:0]                  idx_q;
	logic [PW-1:0]                  per_q;
	logic [PW-1:0]                  rem_q;
	logic [CW-1:0]                  dvd_q;
	logic [ptd_pkg::BIT_W-1:0]      bit_q;
	logic [NS-1:0]                  mask_q;
	logic [EW-1:0]                  emit_q;

	logic                           res_valid_q;
	logic                           kind_q;
	logic                           status_q;
	logic [ptd_pkg::TASK_W-1:0]     due_task_q;
	logic                           last_q;

	ptd_pkg::slot_entry_t ent, new_ent;
	logic                 cmd_rej, cmd_wr, slot_ok;
	logic                 out_free, idx_last, run_div;
	logic [PW:0]          trial;
	logic [PW-1:0]        rem_next;
	logic [IW-1:0]        low_idx;
	logic [NS-1:0]        mask_rest;
	logic                 emit_last;
	logic                 cmd_fire, emit_fire;

	assign ent      = rd_vld_q ? rd_data_q : '0;
	assign out_free = !res_valid_q || res.ready;
	assign idx_last = (idx_q == IW'(NS - 1));
	assign run_div  = ent.active && (ent.period != '0);
	assign slot_ok  = (int'(slot_q) < NS);

	always_comb begin
		trial    = {rem_q, dvd_q[CW-1]};
		rem_next = (trial >= {1'b0, per_q}) ? PW'(trial - {1'b0, per_q}) : trial[PW-1:0];
	end

	always_comb begin
		new_ent = ent;
		cmd_rej = ptd_pkg::STAT_REJ;
		cmd_wr  = 1'b0;
		if (slot_ok) begin
			case (op_q)
				ptd_pkg::OP_CREATE: begin
					if (!ent.used) begin
						new_ent = '{used: 1'b1, active: 1'b1, period: per_in_q};
						cmd_rej = ptd_pkg::STAT_OK;
						cmd_wr  = 1'b1;
					end
				end
				ptd_pkg::OP_DELETE: begin
					new_ent = '0;
					cmd_rej = ptd_pkg::STAT_OK;
					cmd_wr  = 1'b1;
				end
				ptd_pkg::OP_SUSPEND: begin
					if (ent.used) begin
						new_ent.active = 1'b0;
						cmd_rej        = ptd_pkg::STAT_OK;
						cmd_wr         = 1'b1;
					end
				end
				ptd_pkg::OP_ACTIVATE: begin
					if (ent.used) begin
						new_ent.active = 1'b1;
						cmd_rej        = ptd_pkg::STAT_OK;
						cmd_wr         = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		low_idx = '0;
		for (int i = NS - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				low_idx = IW'(i);
			end
		end
		mask_rest = mask_q & (mask_q - NS'(1));
		emit_last = (mask_rest == '0) || (emit_q == EW'(ptd_pkg::MAX_OUT - 1));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ptd_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					state_d = (cmd.opcode == ptd_pkg::OP_TICK) ? ptd_pkg::ST_TRD
						: ptd_pkg::ST_CRD;
				end
			end
			ptd_pkg::ST_CRD: begin
				if (out_free) begin
					state_d = ptd_pkg::ST_IDLE;
				end
			end
			ptd_pkg::ST_TRD: begin
				state_d = ptd_pkg::ST_TCHK;
			end
			ptd_pkg::ST_TCHK: begin
				if (run_div) begin
					state_d = ptd_pkg::ST_TDIV;
				end else begin
					state_d = idx_last ? ptd_pkg::ST_EMIT : ptd_pkg::ST_TRD;
				end
			end
			ptd_pkg::ST_TDIV: begin
				if (bit_q == '0) begin
					state_d = idx_last ? ptd_pkg::ST_EMIT : ptd_pkg::ST_TRD;
				end
			end
			ptd_pkg::ST_EMIT: begin
				if (mask_q == '0) begin
					state_d = ptd_pkg::ST_IDLE;
				end else if (out_free && emit_last) begin
					state_d = ptd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ptd_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.ready = (state_q == ptd_pkg::ST_IDLE);
		unique case (state_q)
			ptd_pkg::ST_IDLE: rd_addr = IW'(cmd.slot);
			ptd_pkg::ST_CRD:  rd_addr = IW'(slot_q);
			default:          rd_addr = idx_q;
		endcase
		cmd_fire  = (state_q == ptd_pkg::ST_CRD) && out_free;
		emit_fire = (state_q == ptd_pkg::ST_EMIT) && (mask_q != '0) && out_free;
	end

	assign res.valid    = res_valid_q;
	assign res.kind     = kind_q;
	assign res.status   = status_q;
	assign res.due_task = due_task_q;
	assign res.last     = last_q;

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
		rd_vld_q  <= vld_q[rd_addr];
		if (cmd_fire && cmd_wr) begin
			mem_q[IW'(slot_q)] <= new_ent;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_q     <= cmd.opcode;
			slot_q   <= cmd.slot;
			per_in_q <= cmd.period;
		end
		if (state_q == ptd_pkg::ST_TCHK) begin
			rem_q <= '0;
			dvd_q <= tick_q;
			per_q <= ent.period;
			bit_q <= ptd_pkg::BIT_W'(CW - 1);
		end else if (state_q == ptd_pkg::ST_TDIV) begin
			rem_q <= rem_next;
			dvd_q <= {dvd_q[CW-2:0], 1'b0};
			bit_q <= bit_q - 1'b1;
		end
		if (cmd_fire) begin
			kind_q     <= ptd_pkg::KIND_STATUS;
			status_q   <= cmd_rej;
			due_task_q <= '0;
			last_q     <= 1'b1;
		end else if (emit_fire) begin
			kind_q     <= ptd_pkg::KIND_DUE;
			status_q   <= ptd_pkg::STAT_OK;
			due_task_q <= ptd_pkg::TASK_W'(low_idx);
			last_q     <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptd_pkg::ST_IDLE;
			vld_q       <= '0;
			tick_q      <= '0;
			idx_q       <= '0;
			mask_q      <= '0;
			emit_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd_fire && cmd_wr) begin
				vld_q[IW'(slot_q)] <= 1'b1;
			end
			if (cmd.valid && cmd.ready && (cmd.opcode == ptd_pkg::OP_TICK)) begin
				tick_q <= tick_q + 1'b1;
				idx_q  <= '0;
				mask_q <= '0;
				emit_q <= '0;
			end
			if (((state_q == ptd_pkg::ST_TCHK) && !run_div)
				|| ((state_q == ptd_pkg::ST_TDIV) && (bit_q == '0))) begin
				if (!idx_last) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if ((state_q == ptd_pkg::ST_TDIV) && (bit_q == '0) && (rem_next == '0)) begin
				mask_q[idx_q] <= 1'b1;
			end
			if (emit_fire) begin
				mask_q <= emit_last ? '0 : mask_rest;
				emit_q <= emit_q + 1'b1;
			end
			if (cmd_fire || emit_fire) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	`PTD_ASSERT_SAME(a_div_nonzero, clk, arst_n, (state_q == ptd_pkg::ST_TDIV), (per_q != '0))
	`PTD_ASSERT_SAME(a_rem_bound, clk, arst_n, (state_q == ptd_pkg::ST_TDIV), (rem_q < per_q))
	`PTD_ASSERT_NEXT(a_beat_leaves_idle, clk, arst_n, (cmd.valid && cmd.ready), (state_q != ptd_pkg::ST_IDLE))
	`PTD_ASSERT_SAME(a_no_overwrite, clk, arst_n, (res_valid_q && !res.ready), (!cmd_fire && !emit_fire))

endmodule
